FILE: hdl/vpw_pkg.sv
// Shared constants and helper functions for the vertex projection block.
`default_nettype none
package vpw_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int SCREEN_WIDTH_DEF  = 640;
    localparam int SCREEN_HEIGHT_DEF = 480;

    // Quotients are capped at 2^40 before field saturation
    localparam int QUO_W = 41;
    localparam logic [QUO_W-1:0] QCAP = {1'b1, {(QUO_W-1){1'b0}}};

    localparam int NUM_REGS = 8;
    localparam logic [63:0] MAT_RESET [NUM_REGS] = '{
        64'd65536, 64'd0,
        64'd65536 << 32, 64'd0,
        64'd0, 64'd65536,
        64'd0, 64'd65536 << 32
    };

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

    function automatic logic [31:0] sat_s32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/vpw_div.sv
// Bit-serial restoring divider: min(floor(num * 2^FRAC_BITS / den), 2^40).
`default_nettype none
module vpw_div #(
    parameter int NUM_W     = 41,
    parameter int FRAC_BITS = vpw_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [NUM_W-1:0]            i_num,
    input  wire logic [31:0]                 i_den,
    output logic                             o_done,
    output logic [vpw_pkg::QUO_W-1:0]        o_quo
);
    localparam int DW  = NUM_W + FRAC_BITS;
    localparam int CW  = $clog2(DW + 1);
    localparam int QW  = vpw_pkg::QUO_W;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_dvd;
    logic [31:0]   r_rem;
    logic [31:0]   r_den;
    logic [QW-1:0] r_quo;
    logic          r_ovf;
    logic          r_zero;

    logic [32:0]   n_trial;
    logic          n_ge;
    logic [32:0]   n_diff;

    always_comb begin
        n_trial = {r_rem, r_dvd[DW-1]};
        n_ge    = n_trial >= {1'b0, r_den};
        n_diff  = n_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= {i_num, {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_den  <= i_den;
            r_quo  <= '0;
            r_ovf  <= 1'b0;
            r_zero <= (i_den == '0) && (i_num == '0);
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_rem <= n_ge ? n_diff[31:0] : n_trial[31:0];
            // a set bit pushed out of the top means the quotient is past the cap
            r_ovf <= r_ovf | r_quo[QW-1];
            r_quo <= {r_quo[QW-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_zero ? '0 :
                    (r_ovf || (r_quo > vpw_pkg::QCAP)) ? vpw_pkg::QCAP : r_quo;

endmodule
`default_nettype wire

FILE: hdl/vertex_project_to_window.sv
// Vertex projection: matrix transform, perspective divide, viewport and triangle cull.
// Each vertex passes through the input transfer, 12 products on the single 32x32
// multiplier (each followed by an accumulate), a load state, the divider start and six
// bit-serial dividers running side by side (NUM_W = 32 + clog2(max(width,height,255)+1)),
// then the done flag. Results of a triangle with all clip w >= 0 leave as three output
// transfers after its third vertex, the last one with tlast high; the block takes no
// vertex while those are pending. The matrix registers sit at byte addresses 8*i; the
// user must write them only while idle, as the block itself does not enforce this.
`default_nettype none
module vertex_project_to_window #(
    parameter int FRAC_BITS     = vpw_pkg::FRAC_BITS_DEF,
    parameter int SCREEN_WIDTH  = vpw_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = vpw_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v
    input  wire logic [159:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // win_x, win_y, depth, inv_w, tex_s, tex_t
    output logic [191:0]      m_axis_tdata,
    output logic              m_axis_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    localparam int KWH   = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int KMAX  = (KWH > 255) ? KWH : 255;
    localparam int NUM_W = 32 + $clog2(KMAX + 1);
    localparam int QW    = vpw_pkg::QUO_W;
    localparam int NLANE = 6;

    localparam logic signed [63:0] HALF_W = 64'(SCREEN_WIDTH / 2) << FRAC_BITS;
    localparam logic signed [63:0] HALF_H = 64'(SCREEN_HEIGHT / 2) << FRAC_BITS;
    localparam logic signed [63:0] FULL_H = 64'(SCREEN_HEIGHT) << FRAC_BITS;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_ACC  = 6'b000100,
        S_LOAD = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state              r_state;
    logic [63:0]         r_mat [vpw_pkg::NUM_REGS];
    logic signed [31:0]  r_pos [3];
    logic signed [31:0]  r_u;
    logic signed [31:0]  r_v;
    logic [1:0]          r_k;
    logic [1:0]          r_col;
    logic signed [63:0]  r_prod;
    logic signed [63:0]  r_acc;
    logic signed [31:0]  r_clip [4];
    logic [191:0]        r_cur;
    logic [191:0]        r_held [2];
    logic [1:0]          r_cnt;
    logic                r_rej;
    logic [1:0]          r_oidx;
    logic                r_start;

    logic                  cfg_wr;
    logic [2:0]            cfg_idx;
    logic signed [31:0]    el_mul;
    logic signed [31:0]    el_off;
    logic [63:0]           w_mul;
    logic [63:0]           w_off;
    logic signed [63:0]    n_acc;
    logic [NUM_W-1:0]      div_num  [NLANE];
    logic [31:0]           div_den  [NLANE];
    logic [NLANE-1:0]      div_done;
    logic [QW-1:0]         div_quo  [NLANE];
    logic signed [63:0]    t_x, t_y, t_s, t_t;
    logic [191:0]          n_cur;
    logic                  w_neg;
    logic                  n_rej;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = r_mat[cfg_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= vpw_pkg::MAT_RESET;
        end else if (cfg_wr) begin
            r_mat[cfg_idx] <= pwdata;
        end
    end

    // matrix element for the current product and the translation row
    always_comb begin
        w_mul  = r_mat[{r_k, r_col[1]}];
        w_off  = r_mat[{2'd3, r_col[1]}];
        el_mul = r_col[0] ? w_mul[63:32] : w_mul[31:0];
        el_off = r_col[0] ? w_off[63:32] : w_off[31:0];
        n_acc  = ((r_k == 2'd0) ? 64'(el_off) : r_acc) + (r_prod >>> FRAC_BITS);
    end

    // divider lanes: win_x, win_y, depth, inv_w, tex_s, tex_t
    always_comb begin
        div_num[0] = NUM_W'(vpw_pkg::mag32(r_clip[0])) * NUM_W'(SCREEN_WIDTH);
        div_num[1] = NUM_W'(vpw_pkg::mag32(r_clip[1])) * NUM_W'(SCREEN_HEIGHT);
        div_num[2] = NUM_W'(65535) << FRAC_BITS;
        div_num[3] = NUM_W'(1) << FRAC_BITS;
        div_num[4] = NUM_W'(vpw_pkg::mag32(r_u)) * NUM_W'(255);
        div_num[5] = NUM_W'(vpw_pkg::mag32(r_v)) * NUM_W'(255);
        div_den[0] = vpw_pkg::mag32(r_clip[3]);
        div_den[1] = vpw_pkg::mag32(r_clip[3]);
        div_den[2] = vpw_pkg::mag32(r_clip[2]);
        div_den[3] = vpw_pkg::mag32(r_clip[3]);
        div_den[4] = vpw_pkg::mag32(r_clip[3]);
        div_den[5] = vpw_pkg::mag32(r_clip[3]);
    end

    for (genvar g = 0; g < NLANE; g++) begin : g_div
        vpw_div #(
            .NUM_W     (NUM_W),
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_start),
            .i_num   (div_num[g]),
            .i_den   (div_den[g]),
            .o_done  (div_done[g]),
            .o_quo   (div_quo[g])
        );
    end

    // apply signs, offsets and field saturation
    always_comb begin
        w_neg = r_clip[3][31];
        t_x = (r_clip[0][31] ^ w_neg) ? -$signed(64'(div_quo[0])) : $signed(64'(div_quo[0]));
        t_y = (r_clip[1][31] ^ w_neg) ? -$signed(64'(div_quo[1])) : $signed(64'(div_quo[1]));
        t_s = (r_u[31] ^ w_neg) ? -$signed(64'(div_quo[4])) : $signed(64'(div_quo[4]));
        t_t = (r_v[31] ^ w_neg) ? -$signed(64'(div_quo[5])) : $signed(64'(div_quo[5]));
        n_cur[31:0]    = vpw_pkg::sat_s32(HALF_W + t_x);
        n_cur[63:32]   = vpw_pkg::sat_s32(FULL_H - (HALF_H + t_y));
        n_cur[95:64]   = (div_quo[2][QW-1:32] != '0) ? 32'hFFFF_FFFF : div_quo[2][31:0];
        n_cur[127:96]  = (div_quo[3][QW-1:32] != '0) ? 32'hFFFF_FFFF : div_quo[3][31:0];
        n_cur[159:128] = vpw_pkg::sat_s32(t_s);
        n_cur[191:160] = vpw_pkg::sat_s32(t_t);
        n_rej = (r_cnt == 2'd0) ? w_neg : (r_rej | w_neg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_rej   <= 1'b0;
            r_start <= 1'b0;
            r_oidx  <= '0;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_k     <= '0;
                        r_col   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= n_acc;
                    if (r_k == 2'd2) begin
                        r_clip[r_col] <= vpw_pkg::sat_s32(n_acc);
                        r_k           <= '0;
                        if (r_col == 2'd3) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_col   <= r_col + 1'b1;
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_LOAD: begin
                    r_start <= 1'b1;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (&div_done) begin
                        r_cur <= n_cur;
                        if (r_cnt != 2'd2) begin
                            r_held[r_cnt[0]] <= n_cur;
                            r_cnt            <= r_cnt + 1'b1;
                            r_rej            <= n_rej;
                            r_state          <= S_IDLE;
                        end else begin
                            r_cnt  <= '0;
                            r_rej  <= 1'b0;
                            r_oidx <= '0;
                            // drop the whole triangle when any w was negative
                            r_state <= n_rej ? S_IDLE : S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        if (r_oidx == 2'd2) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_oidx <= r_oidx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload: input capture and multiplier
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_pos[0] <= s_axis_tdata[31:0];
            r_pos[1] <= s_axis_tdata[63:32];
            r_pos[2] <= s_axis_tdata[95:64];
            r_u      <= s_axis_tdata[127:96];
            r_v      <= s_axis_tdata[159:128];
        end
        if (r_state == S_MUL) begin
            r_prod <= 64'(r_pos[r_k]) * 64'(el_mul);
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tlast  = (r_oidx == 2'd2);
    assign m_axis_tdata  = (r_oidx == 2'd2) ? r_cur : r_held[r_oidx[0]];

endmodule
`default_nettype wire

FILE: hdl/vpw_chk.sv
// Port-level checks for the vertex projection block and their binding.
`default_nettype none
module vpw_chk (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [191:0] m_axis_tdata,
    input wire logic         m_axis_tlast
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled output changed");

    // never take a vertex while results are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while output pending");

    // the closing transfer of a triangle ends the burst
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("output continued after last");

    // reset leaves the block idle and ready
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("not idle after reset");

endmodule

bind vertex_project_to_window vpw_chk u_vpw_chk (.*);
`default_nettype wire
